// ===== sv/mhfb_pkg.sv =====
// Shared types and constants of the multicast hash filter builder.
// Holds the status codes, the CRC-32 constants and a constant-only CRC helper.
// No dependencies.
package mhfb_pkg;

	typedef logic [1:0] status_t;

	localparam status_t ST_ADDED   = 2'd0;
	localparam status_t ST_FULL    = 2'd1;
	localparam status_t ST_CLEARED = 2'd2;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam int          ADDR_W   = 48;
	localparam int          HASH_W   = 6;
	localparam int          HASH_LSB = 26;

	// Reflected CRC-32 over a 48-bit address, byte 0 (bits 47:40) first.
	// Called with constant arguments only, to build the XOR columns.
	function automatic logic [31:0] crc_lin(input logic [31:0] init,
		input logic [ADDR_W-1:0] data);
		logic [31:0] crc;
		crc = init;
		for (int k = 0; k < 6; k++) begin
			crc[7:0] = crc[7:0] ^ data[ADDR_W-1-8*k -: 8];
			for (int b = 0; b < 8; b++) begin
				crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : 32'h0);
			end
		end
		return crc;
	endfunction

endpackage

// ===== sv/multicast_hash_filter_builder_core.sv =====
// Multicast hash filter builder: input register, hash and mask update, result register.
// Depends on mhfb_pkg for status codes and the CRC column constants.
// One item per cycle sustained while no result is held back by out_ready.
// Only a result held back by out_ready stalls the input side.
// The CRC is a fixed XOR network (one column per address bit) feeding a 6-bit index.
// Reset (arst_n low, asynchronous) empties the list, clears the mask, promiscuous to 0.
// No clearing pass; the block accepts items as soon as reset is released.
module multicast_hash_filter_builder_core #(
	parameter int MAX_ADDRESSES = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      action,
	input  logic [47:0]               group_address,
	output logic                      out_valid,
	input  logic                      out_ready,
	output mhfb_pkg::status_t         status,
	output logic [31:0]               filter_low,
	output logic [31:0]               filter_high,
	output logic                      accept_all_phys
);
	import mhfb_pkg::*;

	localparam int CNT_W = $clog2(MAX_ADDRESSES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ADDRESSES);
	localparam logic [31:0] CRC_BASE = crc_lin(CRC_INIT, {ADDR_W{1'b0}});

	logic              promiscuous_q;
	logic              valid_s1;
	logic              action_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [63:0]       hash_mask_q;
	logic [CNT_W-1:0]  count_q;

	logic              out_free;
	logic              adv_s1;
	logic [HASH_W-1:0] term [ADDR_W];
	logic [HASH_W-1:0] hash_idx;
	logic [63:0]       mask_next;
	logic [CNT_W-1:0]  count_next;
	status_t           status_next;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || out_ready;
	assign adv_s1    = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;

	// Register the promiscuous bit on each configuration transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			promiscuous_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			promiscuous_q <= cfg_data;
		end
	end

	// Capture the input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			addr_s1   <= group_address;
		end
	end

	// Select the CRC columns of the set address bits (top six CRC bits only)
	for (genvar i = 0; i < ADDR_W; i++) begin : g_col
		localparam logic [31:0] COL = crc_lin(32'h0, ADDR_W'(1) << i);
		assign term[i] = {HASH_W{addr_s1[i]}} & COL[31:HASH_LSB];
	end

	// Fold the columns into the hash index
	always_comb begin
		hash_idx = CRC_BASE[31:HASH_LSB];
		for (int i = 0; i < ADDR_W; i++) begin
			hash_idx = hash_idx ^ term[i];
		end
	end

	// Decide the next list state and status
	always_comb begin
		mask_next   = hash_mask_q;
		count_next  = count_q;
		status_next = ST_ADDED;
		if (action_s1) begin
			mask_next   = 64'h0;
			count_next  = '0;
			status_next = ST_CLEARED;
		end else if (count_q >= CNT_MAX) begin
			status_next = ST_FULL;
		end else begin
			mask_next   = hash_mask_q | (64'h1 << hash_idx);
			count_next  = count_q + CNT_W'(1);
			status_next = ST_ADDED;
		end
	end

	// Advance list state when the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_mask_q <= 64'h0;
			count_q     <= '0;
		end else if (adv_s1) begin
			hash_mask_q <= mask_next;
			count_q     <= count_next;
		end
	end

	// Hold the result until the output transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status          <= status_next;
			accept_all_phys <= promiscuous_q;
			if (promiscuous_q || (count_next == '0)) begin
				filter_low  <= 32'hFFFF_FFFF;
				filter_high <= 32'hFFFF_FFFF;
			end else begin
				filter_low  <= mask_next[31:0];
				filter_high <= mask_next[63:32];
			end
		end
	end

endmodule
